// ===== design/sxn2_pkg.sv =====
// shared constants, types and the gradient dot product for the 2d simplex noise core
// no dependencies; imported by sxn2_corner and simplex_noise_2d_core
package sxn2_pkg;

  localparam int IN_FRAC_BITS_DEF = 16;

  // op codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // skew factor (sqrt(3)-1)/2 in Q.32, unskew factor (3-sqrt(3))/6 in Q.30
  localparam logic [31:0] SKEW_K32   = 32'd1572067139;
  localparam logic [27:0] UNSKEW_C30 = 28'd226908346;
  localparam logic signed [31:0] ONE30  = 32'sd1073741824;
  localparam logic signed [34:0] HALF30 = 35'sd536870912;

  // output limits, Q2.16
  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  // pipeline depth of the top level
  localparam int N_STG = 14;

  typedef logic signed [31:0] off_t;
  typedef logic [2:0]         grad_t;

  // stage enables of a corner lane
  typedef struct packed {
    logic sq;
    logic dd;
    logic d2;
    logic d4;
    logic mul;
  } crn_en_t;

  // dot product of one of the eight fixed gradients with an offset
  function automatic logic signed [33:0] grad_dot(grad_t g, off_t x, off_t y);
    logic signed [33:0] xe;
    logic signed [33:0] ye;
    xe = 34'(x);
    ye = 34'(y);
    case (g)
      3'd0:    grad_dot = -xe - ye;
      3'd1:    grad_dot = xe;
      3'd2:    grad_dot = -xe;
      3'd3:    grad_dot = xe + ye;
      3'd4:    grad_dot = ye - xe;
      3'd5:    grad_dot = -ye;
      3'd6:    grad_dot = ye;
      3'd7:    grad_dot = xe - ye;
      default: grad_dot = '0;
    endcase
  endfunction

endpackage

// ===== design/sxn2_corner.sv =====
// one corner lane: falloff (0.5-r^2)^4 times gradient dot product, five register stages
// depends on sxn2_pkg
module sxn2_corner import sxn2_pkg::*; (
  input  logic                clk,
  input  crn_en_t             en,
  input  off_t                x_off,
  input  off_t                y_off,
  input  grad_t               grad,
  output logic signed [61:0]  contrib
);

  logic signed [63:0] xsq;
  logic signed [63:0] ysq;
  logic [32:0]        xx_r;
  logic [32:0]        yy_r;
  logic signed [33:0] dot1_r;
  logic signed [33:0] dot2_r;
  logic signed [33:0] dot3_r;
  logic signed [33:0] dot4_r;
  logic signed [34:0] d_c;
  logic [29:0]        d_r;
  logic               pos2_r;
  logic               pos3_r;
  logic               pos4_r;
  logic [59:0]        d_sq;
  logic [28:0]        d2_r;
  logic [57:0]        d2_sq;
  logic [26:0]        d4_r;
  logic signed [61:0] prod;
  logic signed [61:0] contrib_r;

  assign xsq   = x_off * x_off;
  assign ysq   = y_off * y_off;
  assign d_c   = HALF30 - $signed({2'b00, xx_r}) - $signed({2'b00, yy_r});
  assign d_sq  = d_r * d_r;
  assign d2_sq = d2_r * d2_r;
  assign prod  = $signed({1'b0, d4_r}) * dot4_r;

  always_ff @(posedge clk) begin
    if (en.sq) begin
      xx_r   <= xsq[62:30];
      yy_r   <= ysq[62:30];
      dot1_r <= grad_dot(grad, x_off, y_off);
    end
    if (en.dd) begin
      d_r    <= d_c[29:0];
      pos2_r <= (d_c > 35'sd0);
      dot2_r <= dot1_r;
    end
    if (en.d2) begin
      d2_r   <= d_sq[58:30];
      pos3_r <= pos2_r;
      dot3_r <= dot2_r;
    end
    if (en.d4) begin
      d4_r   <= d2_sq[56:30];
      pos4_r <= pos3_r;
      dot4_r <= dot3_r;
    end
    if (en.mul) begin
      contrib_r <= pos4_r ? prod : '0;
    end
  end

  assign contrib = contrib_r;

endmodule

// ===== design/simplex_noise_2d_core.sv =====
// top level of the 2d simplex noise core: pipeline, permutation table, output scaling
// depends on sxn2_pkg and sxn2_corner
//
// Evaluates 2d simplex noise on signed fixed-point points (IN_FRAC_BITS fraction bits)
// and returns a saturated signed Q2.16 value. A word with op = load writes one byte of
// the 256-entry permutation table and yields no result; a word with op = eval yields
// exactly one result, in input order. The table comes out of reset as identity, tracked
// by one valid bit per entry, so no clearing pass is needed. The core is a 14-stage
// pipeline that accepts one word per clock while in_stall is low; each evaluation runs
// through the skew multiply, the unskew multiply, the table read, the squaring, two
// falloff multiplies and the gradient product of each corner, the corner sum and the
// final scale, up to out_valid. A load takes effect for every word accepted after it.
// Stalls are absorbed stage by stage, so bubbles close up and in_stall rises only when
// every stage is full and out_stall is high.
module simplex_noise_2d_core import sxn2_pkg::*; #(
  parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic [7:0]         in_perm_index,
  input  logic [7:0]         in_perm_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_noise_value
);

  localparam int USH = 30 - IN_FRAC_BITS;

  // stage advance chain and valid bits
  logic [N_STG:1] adv;
  logic [N_STG:1] v_r;
  logic [N_STG:1] v_nxt;

  // stage 1: captured word plus x+y
  logic               op1_r;
  logic signed [31:0] x1_r;
  logic signed [31:0] y1_r;
  logic signed [32:0] sxy1_r;
  logic [7:0]         pidx1_r;
  logic [7:0]         pval1_r;
  // stage 2: skew offset
  logic signed [65:0] skew_prod;
  logic               op2_r;
  logic signed [31:0] x2_r;
  logic signed [31:0] y2_r;
  logic signed [31:0] s2_r;
  logic [7:0]         pidx2_r;
  logic [7:0]         pval2_r;
  // stage 3: cell and fraction
  logic signed [32:0] xs_c;
  logic signed [32:0] ys_c;
  logic               op3_r;
  logic [7:0]         ci3_r;
  logic [7:0]         cj3_r;
  logic [29:0]        u3_r;
  logic [29:0]        v3_r;
  logic [7:0]         pidx3_r;
  logic [7:0]         pval3_r;
  // stage 4: u+v
  logic               op4_r;
  logic [7:0]         ci4_r;
  logic [7:0]         cj4_r;
  logic [29:0]        u4_r;
  logic [29:0]        v4_r;
  logic [30:0]        uv4_r;
  logic [7:0]         pidx4_r;
  logic [7:0]         pval4_r;
  // stage 5: unskew term, table access happens on leaving this stage
  logic [58:0]        t_prod;
  logic               op5_r;
  logic [7:0]         ci5_r;
  logic [7:0]         cj5_r;
  logic [29:0]        u5_r;
  logic [29:0]        v5_r;
  logic [28:0]        t5_r;
  logic [7:0]         pidx5_r;
  logic [7:0]         pval5_r;
  // permutation table, reads as identity until an entry is written
  logic [7:0]         ptab_mem [256];
  logic [255:0]       ptab_vld_r;
  logic [7:0]         cj5_inc;
  // stage 6: table read data
  logic [7:0]         ci6_r;
  logic [7:0]         cj6_r;
  logic [29:0]        u6_r;
  logic [29:0]        v6_r;
  logic [28:0]        t6_r;
  logic [7:0]         rd0_r;
  logic [7:0]         rd1_r;
  logic               rv0_r;
  logic               rv1_r;
  // stage 7: corner offsets and gradient picks
  logic [7:0]         pe0;
  logic [7:0]         pe1;
  logic [7:0]         pe_mid;
  logic [7:0]         ci_mid;
  logic               si;
  off_t               x0_c;
  off_t               y0_c;
  off_t               xo_r [3];
  off_t               yo_r [3];
  grad_t              g_r  [3];
  // corner lanes and sum
  crn_en_t            crn_en;
  logic signed [61:0] contrib [3];
  logic signed [63:0] sum13_r;
  // output scaling
  logic signed [63:0] sum_sh;
  logic signed [63:0] scaled;
  logic signed [63:0] res;
  logic signed [17:0] noise_r;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[N_STG] = !v_r[N_STG] || !out_stall;
    for (int k = N_STG - 1; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  // load words end at stage 5, where they write the table
  always_comb begin
    v_nxt = v_r;
    for (int k = 1; k <= N_STG; k++) begin
      if (adv[k]) begin
        if (k == 1) begin
          v_nxt[k] = in_valid;
        end else if (k == 6) begin
          v_nxt[k] = v_r[5] && (op5_r == OP_EVAL);
        end else begin
          v_nxt[k] = v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op1_r   <= in_op;
      x1_r    <= in_x_coord;
      y1_r    <= in_y_coord;
      sxy1_r  <= 33'(in_x_coord) + 33'(in_y_coord);
      pidx1_r <= in_perm_index;
      pval1_r <= in_perm_value;
    end
  end

  // stage 2: s = floor((x+y) * K)
  assign skew_prod = sxy1_r * $signed({1'b0, SKEW_K32});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op2_r   <= op1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      s2_r    <= skew_prod[63:32];
      pidx2_r <= pidx1_r;
      pval2_r <= pval1_r;
    end
  end

  // stage 3: skewed point split into wrapped cell and Q.30 fraction
  assign xs_c = 33'(x2_r) + 33'(s2_r);
  assign ys_c = 33'(y2_r) + 33'(s2_r);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      op3_r   <= op2_r;
      ci3_r   <= xs_c[IN_FRAC_BITS +: 8];
      cj3_r   <= ys_c[IN_FRAC_BITS +: 8];
      u3_r    <= 30'(xs_c[IN_FRAC_BITS-1:0]) << USH;
      v3_r    <= 30'(ys_c[IN_FRAC_BITS-1:0]) << USH;
      pidx3_r <= pidx2_r;
      pval3_r <= pval2_r;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      op4_r   <= op3_r;
      ci4_r   <= ci3_r;
      cj4_r   <= cj3_r;
      u4_r    <= u3_r;
      v4_r    <= v3_r;
      uv4_r   <= 31'(u3_r) + 31'(v3_r);
      pidx4_r <= pidx3_r;
      pval4_r <= pval3_r;
    end
  end

  // stage 5: t = floor((u+v) * C)
  assign t_prod = uv4_r * UNSKEW_C30;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      op5_r   <= op4_r;
      ci5_r   <= ci4_r;
      cj5_r   <= cj4_r;
      u5_r    <= u4_r;
      v5_r    <= v4_r;
      t5_r    <= t_prod[58:30];
      pidx5_r <= pidx4_r;
      pval5_r <= pval4_r;
    end
  end

  // table: written and read by the word leaving stage 5, so order matches input order
  assign cj5_inc = cj5_r + 8'd1;

  always_ff @(posedge clk) begin
    if (adv[6] && v_r[5]) begin
      if (op5_r == OP_LOAD) begin
        ptab_mem[pidx5_r] <= pval5_r;
      end
      rd0_r <= ptab_mem[cj5_r];
      rd1_r <= ptab_mem[cj5_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptab_vld_r <= '0;
    end else if (adv[6] && v_r[5] && (op5_r == OP_LOAD)) begin
      ptab_vld_r[pidx5_r] <= 1'b1;
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      ci6_r <= ci5_r;
      cj6_r <= cj5_r;
      u6_r  <= u5_r;
      v6_r  <= v5_r;
      t6_r  <= t5_r;
      rv0_r <= ptab_vld_r[cj5_r];
      rv1_r <= ptab_vld_r[cj5_inc];
    end
  end

  // stage 7: unskewed offsets of the three corners and their gradients
  always_comb begin
    pe0    = rv0_r ? rd0_r : cj6_r;
    pe1    = rv1_r ? rd1_r : (cj6_r + 8'd1);
    x0_c   = $signed({2'b00, u6_r}) - $signed({3'b000, t6_r});
    y0_c   = $signed({2'b00, v6_r}) - $signed({3'b000, t6_r});
    // lower triangle steps in i first, upper in j
    si     = (x0_c > y0_c);
    pe_mid = si ? pe0 : pe1;
    ci_mid = si ? (ci6_r + 8'd1) : ci6_r;
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      xo_r[0] <= x0_c;
      yo_r[0] <= y0_c;
      xo_r[1] <= x0_c - (si ? ONE30 : 32'sd0) + $signed({4'b0000, UNSKEW_C30});
      yo_r[1] <= y0_c - (si ? 32'sd0 : ONE30) + $signed({4'b0000, UNSKEW_C30});
      xo_r[2] <= x0_c - ONE30 + $signed({3'b000, UNSKEW_C30, 1'b0});
      yo_r[2] <= y0_c - ONE30 + $signed({3'b000, UNSKEW_C30, 1'b0});
      g_r[0]  <= ci6_r[2:0] + pe0[2:0];
      g_r[1]  <= ci_mid[2:0] + pe_mid[2:0];
      g_r[2]  <= ci6_r[2:0] + 3'd1 + pe1[2:0];
    end
  end

  // stages 8 to 12: corner lanes
  assign crn_en = '{sq: adv[8], dd: adv[9], d2: adv[10], d4: adv[11], mul: adv[12]};

  for (genvar c = 0; c < 3; c++) begin : g_crn
    sxn2_corner u_crn (
      .clk     (clk),
      .en      (crn_en),
      .x_off   (xo_r[c]),
      .y_off   (yo_r[c]),
      .grad    (g_r[c]),
      .contrib (contrib[c])
    );
  end

  // stage 13: Q.60 sum of the corners
  always_ff @(posedge clk) begin
    if (adv[13]) begin
      sum13_r <= 64'(contrib[0]) + 64'(contrib[1]) + 64'(contrib[2]);
    end
  end

  // stage 14: floor to Q.46, times 60, floor to Q.16, saturate
  always_comb begin
    sum_sh = sum13_r >>> 14;
    scaled = sum_sh * 64'sd60;
    res    = scaled >>> 30;
  end

  always_ff @(posedge clk) begin
    if (adv[14]) begin
      if (res > OUT_MAX) begin
        noise_r <= 18'(OUT_MAX);
      end else if (res < OUT_MIN) begin
        noise_r <= 18'(OUT_MIN);
      end else begin
        noise_r <= res[17:0];
      end
    end
  end

  assign out_valid       = v_r[N_STG];
  assign out_noise_value = noise_r;

endmodule

// ===== design/sxn2_chk.sv =====
// port-level checker for simplex_noise_2d_core, attached by bind
// no dependencies beyond the top level's ports
module sxn2_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_noise_value
);

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // input backs up only when the output word is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_noise_value))
    else $error("output word changed under stall");

endmodule

bind simplex_noise_2d_core sxn2_chk u_sxn2_chk (.*);

// ===== sim/simplex_noise_2d_core_test.sv =====
// testbench for simplex_noise_2d_core: permutation loads and noise evaluations
// depends on sxn2_pkg and the core rtl; the scoreboard class predicts every noise word
`timescale 1ns / 100ps

module simplex_noise_2d_core_test;
  import sxn2_pkg::*;

  // scoreboard: own copy of the permutation table and a queue of expected noise words
  class noise_scoreboard;
    logic [7:0] perm_q[256];
    logic signed [17:0] noise_q[$];
    int errors;
    int n_eval;
    int n_load;

    function new();
      for (int k = 0; k < 256; k++) perm_q[k] = k[7:0];
      errors = 0;
      n_eval = 0;
      n_load = 0;
    endfunction

    // arithmetic shift right is floor for signed operands
    function automatic longint falloff(longint ox, longint oy, logic [2:0] g);
      longint d;
      longint d2;
      longint d4;
      longint dot;
      d = 64'sd536870912 - ((ox * ox) >>> 30) - ((oy * oy) >>> 30);
      if (d <= 0) return 0;
      d2 = (d * d) >>> 30;
      d4 = (d2 * d2) >>> 30;
      case (g)
        3'd0: dot = -ox - oy;
        3'd1: dot = ox;
        3'd2: dot = -ox;
        3'd3: dot = ox + oy;
        3'd4: dot = oy - ox;
        3'd5: dot = -oy;
        3'd6: dot = oy;
        default: dot = ox - oy;
      endcase
      return d4 * dot;
    endfunction

    function automatic logic [2:0] grad_of(logic [7:0] a, logic [7:0] b);
      logic [7:0] t;
      t = a + perm_q[b];
      return t[2:0];
    endfunction

    // note an accepted input word
    function void note_word(logic op, logic signed [31:0] xc, logic signed [31:0] yc,
                            logic [7:0] idx, logic [7:0] val);
      longint xe;
      longint ye;
      longint sk;
      longint xs;
      longint ys;
      longint u;
      longint v;
      longint t;
      longint x0;
      longint y0;
      longint x1;
      longint y1;
      longint x2;
      longint y2;
      longint sum;
      longint res;
      logic [7:0] ci;
      logic [7:0] cj;
      logic si;
      longint c30;
      c30 = 64'sd226908346;
      if (op == OP_LOAD) begin
        perm_q[idx] = val;
        n_load++;
        return;
      end
      n_eval++;
      xe = xc;
      ye = yc;
      sk = ((xe + ye) * 64'sd1572067139) >>> 32;
      xs = xe + sk;
      ys = ye + sk;
      ci = xs[23:16];
      cj = ys[23:16];
      u = longint'(xs[15:0]) << 14;
      v = longint'(ys[15:0]) << 14;
      t = ((u + v) * c30) >>> 30;
      x0 = u - t;
      y0 = v - t;
      si = x0 > y0;
      x1 = x0 - (si ? 64'sd1073741824 : 0) + c30;
      y1 = y0 - (si ? 0 : 64'sd1073741824) + c30;
      x2 = x0 - 64'sd1073741824 + 2 * c30;
      y2 = y0 - 64'sd1073741824 + 2 * c30;
      sum = falloff(x0, y0, grad_of(ci, cj));
      sum += falloff(x1, y1, grad_of(ci + {7'd0, si}, cj + {7'd0, !si}));
      sum += falloff(x2, y2, grad_of(ci + 8'd1, cj + 8'd1));
      res = ((sum >>> 14) * 60) >>> 30;
      if (res > 131071) res = 131071;
      if (res < -131072) res = -131072;
      noise_q.push_back(res[17:0]);
    endfunction

    // compare a result word with the oldest expectation
    function void check_word(logic signed [17:0] got);
      logic signed [17:0] want;
      if (noise_q.size() == 0) begin
        $error("noise_value: unexpected word, actual %0d", got);
        errors++;
        return;
      end
      want = noise_q.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_LOAD;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic [7:0]         in_perm_index = '0;
  logic [7:0]         in_perm_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [17:0] out_noise_value;

  noise_scoreboard sb = new();
  // idle rates in percent; zero during the quiet stretch
  int src_idle_pct = 10;
  int snk_idle_pct = 10;

  simplex_noise_2d_core u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver side: random stall, checking at each accepting edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_noise_value);
    out_stall <= rst_n && ($urandom_range(99) < snk_idle_pct);
  end

  // present one word and hold it until accepted; random gaps in front
  task automatic send_word(logic op, logic signed [31:0] xc, logic signed [31:0] yc,
                           logic [7:0] idx, logic [7:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_x_coord <= xc;
    in_y_coord <= yc;
    in_perm_index <= idx;
    in_perm_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, xc, yc, idx, val);
  endtask

  task automatic send_eval(logic signed [31:0] xc, logic signed [31:0] yc);
    send_word(OP_EVAL, xc, yc, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_word(OP_LOAD, $signed($urandom()), $signed($urandom()), idx, val);
  endtask

  // random coordinate: mostly small points near the origin, some full-range
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic drain_all();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.noise_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3 * N_STG) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity table first, extremes of coordinates, lattice points
    send_eval(0, 0);
    send_eval(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_eval(32'sh8000_0000, 32'sh8000_0000);
    send_eval(32'sh7fff_ffff, 32'sh8000_0000);
    send_eval(32'sh8000_0000, 32'sh7fff_ffff);
    send_eval(32'sh0000_8000, 32'sh0000_4000);
    send_eval(32'sh0000_4000, 32'sh0000_8000);
    send_eval(-32'sh0001_0000, 32'sh0001_8000);
    send_eval(32'sh0000_ffff, 32'sh0000_0001);
    // loads at the table ends, then evaluations that read them
    send_load(8'd0, 8'hff);
    send_load(8'hff, 8'h00);
    send_load(8'd1, 8'haa);
    send_load(8'hfe, 8'h55);
    send_eval(32'sh0000_3000, 32'sh0000_2000);
    send_eval(-32'sh0000_3000, -32'sh0000_2000);
    send_eval(32'sh0001_3000, 32'sh0000_7000);
    // sweep that hunts for the saturating peaks of the sum
    for (int k = 0; k < 8; k++)
      send_eval(32'sh0000_1000 * k, -32'sh0000_0800 * k);

    // hold off until the pipe is empty
    drain_all();

    for (int n = 0; n < 2000; n++) begin
      // quiet stretch: no idling on either side
      if (n == 600) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (n == 900) begin
        src_idle_pct = 10;
        snk_idle_pct = 10;
      end
      if (n == 1400) drain_all();
      if ($urandom_range(99) < 15) send_load(8'($urandom()), 8'($urandom()));
      else send_eval(rand_coord(), rand_coord());
    end

    drain_all();
    $display("covered %0d evaluations and %0d table loads, with random idling and stalls",
             sb.n_eval, sb.n_load);
    if (sb.errors == 0 && sb.noise_q.size() == 0) begin
      $display("[simplex_noise_2d_core] OK");
    end else begin
      $display("[simplex_noise_2d_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("[simplex_noise_2d_core] ERROR");
    $finish;
  end

endmodule
